### rtl/amg_pkg.sv
// Package for the adjacency matrix graph store: operation codes, status codes
// and default sizes. No dependencies.
`timescale 1ns / 1ps
package amg_pkg;
	localparam int MaxVerticesDefault = 32;
	localparam logic [2:0] FUNC_ADD_V = 3'd0;
	localparam logic [2:0] FUNC_REM_V = 3'd1;
	localparam logic [2:0] FUNC_ADD_E = 3'd2;
	localparam logic [2:0] FUNC_REM_E = 3'd3;
	localparam logic [2:0] FUNC_COST  = 3'd4;
	localparam logic [2:0] FUNC_ADJ   = 3'd5;
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DUP  = 2'd2;
	typedef logic [7:0] label_t;
	typedef logic signed [31:0] weight_t;
endpackage

### rtl/adjacency_matrix_graph_store.sv
// Top level of the adjacency matrix graph store: label table, weight matrix
// memory and the sequencer that runs each operation. Uses amg_pkg.
//
// channel  direction  handshake        payload
// in       to block   in_valid/ready   func first_label second_label weight
// out      from block out_valid/ready  status cost neighbor_label has_neighbor last
//
// Each transaction runs a label search, one slot a cycle with every slot
// compared against both labels and against zero, then the operation. Add
// vertex, edge writes and spare codes go from dispatch to the result; get
// cost reads the matrix through S_RD and S_RDW first; get adjacent scans
// one row, a read state and a data state a slot, plus output stalls. Remove
// vertex moves the matrix entry by entry through the single memory port, a
// read and a write an entry. After reset a clearing pass over the whole
// memory runs before the first transaction is taken. in_ready is low while
// an item is at work or while its final result waits.
`timescale 1ns / 1ps
module adjacency_matrix_graph_store
	import amg_pkg::*;
#(
	parameter int MAX_VERTICES = MaxVerticesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  first_label,
	input  logic [7:0]  second_label,
	input  logic signed [31:0] weight,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic signed [31:0] cost,
	output logic [7:0]  neighbor_label,
	output logic        has_neighbor,
	output logic        last
);
	localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int AW = 2 * SW;
	localparam int DEPTH = 1 << AW;
	localparam logic [SW:0] NV = (SW + 1)'(MAX_VERTICES);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_VERTICES - 1);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SRCH   = 4'd2;
	localparam logic [3:0] S_DISP   = 4'd3;
	localparam logic [3:0] S_RD     = 4'd4;
	localparam logic [3:0] S_RDW    = 4'd5;
	localparam logic [3:0] S_ADJ    = 4'd6;
	localparam logic [3:0] S_ADJW   = 4'd7;
	localparam logic [3:0] S_MVR    = 4'd8;
	localparam logic [3:0] S_MVW    = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;
	localparam logic [3:0] S_LBL    = 4'd11;

	logic [3:0] state_q;
	label_t labels_q [MAX_VERTICES];
	logic [31:0] mem [DEPTH];
	logic [31:0] rd_q;

	logic [2:0]  func_q;
	label_t      a_q, b_q;
	logic [31:0] w_q;
	logic [SW:0] idx_q;
	logic [SW-1:0] fi_q, si_q, empty_q;
	logic        fa_q, fb_q, fe_q;
	// move sweep: pass 0 rows, pass 1 columns
	logic        pass_q;
	logic [SW-1:0] r_q, c_q;
	logic [AW:0] clr_q;
	// pending neighbour item
	logic        pend_q;
	label_t      pl_q;

	logic        mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;
	logic        mem_re;

	logic [1:0]  status_q;
	logic [31:0] cost_q;
	label_t      nb_q;
	logic        has_q, last_q, ov_q;
	logic        out_free, emit;

	assign in_ready = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign status = status_q;
	assign cost = cost_q;
	assign neighbor_label = nb_q;
	assign has_neighbor = has_q;
	assign last = last_q;

	// a new result may be loaded once the output register is free
	assign out_free = !ov_q || out_ready;
	assign emit = out_free && ((state_q == S_OUT) ||
		(state_q == S_ADJW && rd_q != 32'd0 && pend_q));

	// single-port weight memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mem_ra];
	end

	// source and destination of the current move step
	logic [SW-1:0] mv_r, mv_c;
	logic          mv_zero;
	always_comb begin
		mv_r = r_q;
		mv_c = c_q;
		mv_zero = 1'b0;
		if (!pass_q) begin
			if (r_q == LAST_SLOT) mv_zero = 1'b1;
			else mv_r = r_q + 1'b1;
		end else begin
			if (c_q == LAST_SLOT) mv_zero = 1'b1;
			else mv_c = c_q + 1'b1;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = {fi_q, si_q};
		mem_wd = w_q;
		mem_re = 1'b0;
		mem_ra = {fi_q, si_q};
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q[AW-1:0];
				mem_wd = '0;
			end
			S_DISP: begin
				mem_we = (func_q == FUNC_ADD_E) || (func_q == FUNC_REM_E);
				mem_wd = (func_q == FUNC_ADD_E) ? w_q : 32'd0;
				mem_re = (func_q == FUNC_COST);
			end
			S_ADJ: begin
				mem_re = 1'b1;
				mem_ra = {fi_q, idx_q[SW-1:0]};
			end
			S_MVR: begin
				mem_re = 1'b1;
				mem_ra = {mv_r, mv_c};
			end
			S_MVW: begin
				mem_we = 1'b1;
				mem_wa = {r_q, c_q};
				mem_wd = mv_zero ? 32'd0 : rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			ov_q <= 1'b0;
			pend_q <= 1'b0;
			for (int i = 0; i < MAX_VERTICES; i++)
				labels_q[i] <= '0;
		end else begin
			// raise on a new result, drop the result once taken
			if (emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW + 1)'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						func_q <= func;
						a_q <= first_label;
						b_q <= second_label;
						w_q <= weight;
						idx_q <= '0;
						fa_q <= 1'b0;
						fb_q <= 1'b0;
						fe_q <= 1'b0;
						fi_q <= '0;
						si_q <= '0;
						empty_q <= '0;
						state_q <= S_SRCH;
					end
				end
				// one slot a cycle: first match of each label and first empty
				S_SRCH: begin
					if (!fa_q && labels_q[idx_q[SW-1:0]] == a_q) begin
						fa_q <= 1'b1;
						fi_q <= idx_q[SW-1:0];
					end
					if (!fb_q && labels_q[idx_q[SW-1:0]] == b_q) begin
						fb_q <= 1'b1;
						si_q <= idx_q[SW-1:0];
					end
					if (!fe_q && labels_q[idx_q[SW-1:0]] == 8'd0) begin
						fe_q <= 1'b1;
						empty_q <= idx_q[SW-1:0];
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == NV - 1'b1)
						state_q <= S_DISP;
				end
				S_DISP: begin
					status_q <= (func_q != FUNC_ADD_V) ? ST_OK :
						(fa_q ? ST_DUP : (fe_q ? ST_OK : ST_FULL));
					cost_q <= '0;
					nb_q <= '0;
					has_q <= 1'b0;
					last_q <= 1'b1;
					idx_q <= '0;
					pend_q <= 1'b0;
					unique case (func_q)
						FUNC_ADD_V: begin
							// take the first empty slot unless the label is held
							if (!fa_q && fe_q) labels_q[empty_q] <= a_q;
							state_q <= S_OUT;
						end
						FUNC_REM_V: begin
							r_q <= fi_q;
							c_q <= '0;
							pass_q <= 1'b0;
							state_q <= S_LBL;
						end
						FUNC_COST: state_q <= S_RD;
						FUNC_ADJ:  state_q <= S_ADJ;
						default:   state_q <= S_OUT;
					endcase
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					cost_q <= rd_q;
					state_q <= S_OUT;
				end
				// scan row: read issued here, data seen in S_ADJW
				S_ADJ: state_q <= S_ADJW;
				S_ADJW: begin
					if (out_free) begin
						if (rd_q != 32'd0) begin
							// flush previous neighbour, hold this one
							if (pend_q) begin
								nb_q <= pl_q;
								has_q <= 1'b1;
								last_q <= 1'b0;
							end
							pend_q <= 1'b1;
							pl_q <= labels_q[idx_q[SW-1:0]];
						end
						if (idx_q == NV - 1'b1)
							state_q <= S_OUT;
						else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_ADJ;
						end
					end
				end
				// compact the label table in one step
				S_LBL: begin
					for (int i = 0; i < MAX_VERTICES - 1; i++)
						if (SW'(i) >= fi_q) labels_q[i] <= labels_q[i + 1];
					labels_q[MAX_VERTICES - 1] <= '0;
					state_q <= S_MVR;
				end
				S_MVR: state_q <= S_MVW;
				// advance along the row, then to the next row, then to the column pass
				S_MVW: begin
					if (c_q != LAST_SLOT) begin
						c_q <= c_q + 1'b1;
						state_q <= S_MVR;
					end else if (r_q != LAST_SLOT) begin
						r_q <= r_q + 1'b1;
						c_q <= pass_q ? fi_q : '0;
						state_q <= S_MVR;
					end else if (!pass_q) begin
						pass_q <= 1'b1;
						r_q <= '0;
						c_q <= fi_q;
						state_q <= S_MVR;
					end else
						state_q <= S_OUT;
				end
				// final result once the output register is free
				S_OUT: begin
					if (out_free) begin
						last_q <= 1'b1;
						if (func_q == FUNC_ADJ) begin
							has_q <= pend_q;
							nb_q <= pend_q ? pl_q : 8'd0;
						end
						pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### sim/tb_adjacency_matrix_graph_store.sv
// Self-checking testbench for the adjacency matrix graph store.
// It runs directed and random operations and checks every result against a graph
// model kept in the testbench. Depends on amg_pkg and adjacency_matrix_graph_store.
`timescale 1ns / 1ps
module tb_adjacency_matrix_graph_store;
	import amg_pkg::*;

	localparam int NV = MaxVerticesDefault;
	localparam int STALL_LIMIT = 40000;
	localparam logic [2:0] FUNC_SPARE6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE7 = 3'd7;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [2:0] func;
		label_t     a;
		label_t     b;
		weight_t    w;
		idle_mode_t mode;
		bit         drain;
	} graph_op_t;

	typedef struct {
		logic [1:0] status;
		weight_t    cost;
		label_t     nb;
		logic       has;
		logic       last;
	} graph_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] func = '0;
	logic [7:0] first_label = '0;
	logic [7:0] second_label = '0;
	logic signed [31:0] weight = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic signed [31:0] cost;
	logic [7:0] neighbor_label;
	logic has_neighbor;
	logic last;

	graph_op_t   pending_ops[$];
	graph_resp_t expected_resps[$];
	label_t      model_labels[NV];
	weight_t     model_weights[NV][NV];
	idle_mode_t  recv_mode = IDLE_NONE;
	bit          in_taken = 1'b0;
	bit          stim_done = 1'b0;
	int          mismatches = 0;
	int          ops_sent = 0;
	int          resps_seen = 0;
	int          quiet_cycles = 0;

	adjacency_matrix_graph_store uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .first_label(first_label), .second_label(second_label),
		.weight(weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cost(cost), .neighbor_label(neighbor_label),
		.has_neighbor(has_neighbor), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// First slot holding the label, or slot 0 when none does
	function automatic int slot_of_label(label_t lbl);
		for (int i = 0; i < NV; i++)
			if (model_labels[i] == lbl)
				return i;
		return 0;
	endfunction

	function automatic bit label_held(label_t lbl);
		for (int i = 0; i < NV; i++)
			if (model_labels[i] == lbl)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic graph_resp_t make_resp(logic [1:0] st, weight_t c, label_t n,
			logic h, logic l);
		graph_resp_t r;
		r.status = st;
		r.cost = c;
		r.nb = n;
		r.has = h;
		r.last = l;
		return r;
	endfunction

	// Append one expected result to the scoreboard
	task automatic expect_resp(graph_resp_t r);
		expected_resps.insert(expected_resps.size(), r);
	endtask

	// Apply one operation to the graph model and queue the results it yields
	task automatic apply_graph_op(graph_op_t op);
		int fs;
		int ss;
		int hits;
		bit placed;
		fs = slot_of_label(op.a);
		ss = slot_of_label(op.b);
		hits = 0;
		placed = 1'b0;
		case (op.func)
			FUNC_ADD_V: begin
				if (label_held(op.a)) begin
					expect_resp(make_resp(ST_DUP, '0, '0, 1'b0, 1'b1));
				end else begin
					for (int i = 0; i < NV && !placed; i++)
						if (model_labels[i] == 8'd0) begin
							model_labels[i] = op.a;
							placed = 1'b1;
						end
					expect_resp(make_resp(placed ? ST_OK : ST_FULL, '0, '0, 1'b0, 1'b1));
				end
			end
			FUNC_REM_V: begin
				// compact labels, rows and columns down over the removed slot
				for (int r = fs; r < NV - 1; r++)
					model_labels[r] = model_labels[r + 1];
				model_labels[NV - 1] = '0;
				for (int r = fs; r < NV - 1; r++)
					model_weights[r] = model_weights[r + 1];
				for (int c = 0; c < NV; c++)
					model_weights[NV - 1][c] = '0;
				for (int r = 0; r < NV; r++) begin
					for (int c = fs; c < NV - 1; c++)
						model_weights[r][c] = model_weights[r][c + 1];
					model_weights[r][NV - 1] = '0;
				end
				expect_resp(make_resp(ST_OK, '0, '0, 1'b0, 1'b1));
			end
			FUNC_ADD_E: begin
				model_weights[fs][ss] = op.w;
				expect_resp(make_resp(ST_OK, '0, '0, 1'b0, 1'b1));
			end
			FUNC_REM_E: begin
				model_weights[fs][ss] = '0;
				expect_resp(make_resp(ST_OK, '0, '0, 1'b0, 1'b1));
			end
			FUNC_COST: expect_resp(make_resp(ST_OK, model_weights[fs][ss], '0, 1'b0, 1'b1));
			FUNC_ADJ: begin
				for (int i = 0; i < NV; i++)
					if (model_weights[fs][i] != 0) begin
						expect_resp(make_resp(ST_OK, '0, model_labels[i], 1'b1, 1'b0));
						hits++;
					end
				if (hits == 0)
					expect_resp(make_resp(ST_OK, '0, '0, 1'b0, 1'b1));
				else
					expected_resps[$].last = 1'b1;
			end
			default: expect_resp(make_resp(ST_OK, '0, '0, 1'b0, 1'b1));
		endcase
	endtask

	// Hold the payload until accepted, then present the next pending transaction
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_ops.size() > 0 &&
					(pending_ops[0].drain ? expected_resps.size() == 0 :
					!((pending_ops[0].mode == IDLE_SEND && $urandom_range(99) < 63) ||
					(pending_ops[0].mode == IDLE_BOTH && $urandom_range(99) < 6)))) begin
				func <= pending_ops[0].func;
				first_label <= pending_ops[0].a;
				second_label <= pending_ops[0].b;
				weight <= pending_ops[0].w;
				recv_mode = pending_ops[0].mode;
				void'(pending_ops.pop_front());
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel according to the current mode
	always @(negedge clk) begin
		if (recv_mode == IDLE_RECV)
			out_ready <= ($urandom_range(99) >= 63);
		else if (recv_mode == IDLE_BOTH)
			out_ready <= ($urandom_range(99) >= 6);
		else
			out_ready <= 1'b1;
	end

	// Predict on accepted input; compare accepted results with the oldest expectation
	always @(posedge clk) begin
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			apply_graph_op('{func, first_label, second_label, weight, IDLE_NONE, 1'b0});
			ops_sent++;
		end
		if (out_valid && out_ready) begin
			resps_seen++;
			if (expected_resps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status=%0d cost=%0d nb=%0d has=%0d last=%0d",
						status, cost, neighbor_label, has_neighbor, last);
			end else begin
				graph_resp_t e;
				e = expected_resps.pop_front();
				if (status !== e.status || cost !== e.cost || neighbor_label !== e.nb ||
						has_neighbor !== e.has || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp st=%0d cost=%0d nb=%0d has=%0d last=%0d",
							" / got st=%0d cost=%0d nb=%0d has=%0d last=%0d"},
							e.status, e.cost, e.nb, e.has, e.last,
							status, cost, neighbor_label, has_neighbor, last);
				end
			end
		end
	end

	// Watchdog: end the run after too long without any transaction
	always @(posedge clk) begin
		if (in_taken || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_resps.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_op(logic [2:0] f, label_t a, label_t b, weight_t w,
			idle_mode_t m, bit d);
		graph_op_t op;
		op = '{f, a, b, w, m, d};
		pending_ops.insert(pending_ops.size(), op);
	endtask

	function automatic label_t pick_label();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return label_t'($urandom_range(40, 1));
		else if (r < 88)
			return 8'd0;
		return label_t'($urandom_range(255));
	endfunction

	initial begin
		int r;
		logic [2:0] f;
		idle_mode_t m;
		for (int i = 0; i < NV; i++) begin
			model_labels[i] = '0;
			for (int j = 0; j < NV; j++)
				model_weights[i][j] = '0;
		end

		// directed: duplicates, label zero, weight extremes, unknown labels, spare codes
		queue_op(FUNC_ADD_V, 8'd1, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_V, 8'd2, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_V, 8'd255, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_V, 8'd2, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_V, 8'd0, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADJ, 8'd1, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_E, 8'd1, 8'd2, 32'sh7fffffff, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_E, 8'd1, 8'd255, 32'sh80000000, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_E, 8'd1, 8'd0, -32'sd1, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_E, 8'd255, 8'd1, 32'sh5a5a5a5a, IDLE_NONE, 1'b0);
		queue_op(FUNC_COST, 8'd1, 8'd2, 32'shffffffff, IDLE_NONE, 1'b0);
		queue_op(FUNC_COST, 8'd1, 8'd255, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADJ, 8'd1, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_COST, 8'd77, 8'd200, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_REM_E, 8'd1, 8'd0, 32'sh12345678, IDLE_NONE, 1'b0);
		queue_op(FUNC_SPARE6, 8'd1, 8'd2, 32'sh0f0f0f0f, IDLE_NONE, 1'b0);
		queue_op(FUNC_SPARE7, 8'd255, 8'd255, -32'sd1, IDLE_NONE, 1'b0);
		queue_op(FUNC_REM_V, 8'd2, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADJ, 8'd1, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADJ, 8'd255, 8'd0, 32'sd0, IDLE_NONE, 1'b1);

		// fill the table to overflow, then add zero while full
		for (int i = 0; i < NV; i++)
			queue_op(FUNC_ADD_V, label_t'(100 + i), 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_V, 8'd0, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADD_E, 8'd0, 8'd131, 32'sd9, IDLE_NONE, 1'b0);
		queue_op(FUNC_ADJ, 8'd1, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_REM_V, 8'd131, 8'd0, 32'sd0, IDLE_NONE, 1'b0);
		queue_op(FUNC_REM_V, 8'd1, 8'd0, 32'sd0, IDLE_NONE, 1'b0);

		// random: mostly valid graph operations over a small label pool
		for (int i = 0; i < 76; i++) begin
			r = $urandom_range(99);
			if (r < 25) f = FUNC_ADD_V;
			else if (r < 33) f = FUNC_REM_V;
			else if (r < 58) f = FUNC_ADD_E;
			else if (r < 66) f = FUNC_REM_E;
			else if (r < 80) f = FUNC_COST;
			else if (r < 96) f = FUNC_ADJ;
			else f = ($urandom_range(1) != 0) ? FUNC_SPARE6 : FUNC_SPARE7;
			m = idle_mode_t'(i / 19);
			queue_op(f, pick_label(), pick_label(), weight_t'($urandom), m,
				(i % 40) == 39);
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending_ops.size() == 0 && !in_valid);
		wait (expected_resps.size() == 0);
		repeat (200) @(posedge clk);

		$display("ran %0d operations over every function, table full and label zero cases",
			ops_sent);
		$display("checked %0d results under four handshake idling modes", resps_seen);
		if (mismatches == 0 && expected_resps.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				expected_resps.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
